### rtl/hvd_pkg.sv
package hvd_pkg;

  localparam int unsigned CharWidth   = 8;
  localparam int unsigned NumberWidth = 64;
  localparam int unsigned CountWidth  = 4;
  localparam int unsigned GroupBits   = 7;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_PAIR = 2'd1,
    STATUS_TOO_MANY = 2'd2
  } status_e;

  typedef struct packed {
    logic [NumberWidth-1:0] number;
    status_e                status;
    logic [CountWidth-1:0]  bytes_used;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } nibble_t;

  function automatic nibble_t hex_nibble(input logic [CharWidth-1:0] c);
    nibble_t r;
    r.ok  = 1'b1;
    r.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.nib = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/hvd_if.sv
interface hvd_in_if import hvd_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] ch;
  logic                 new_number;
  logic                 past_end;

  modport source (output valid, ch, new_number, past_end, input ready);
  modport sink (input valid, ch, new_number, past_end, output ready);
endinterface

interface hvd_out_if import hvd_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [NumberWidth-1:0] number;
  status_e                status;
  logic [CountWidth-1:0]  bytes_used;

  modport source (output valid, number, status, bytes_used, input ready);
  modport sink (input valid, number, status, bytes_used, output ready);
endinterface

### rtl/hvd_out_reg.sv
module hvd_out_reg import hvd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  result_t res_i,
  output logic    free_o,
  hvd_out_if.source out_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = wr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && wr_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.number     = res_q.number;
  assign out_o.status     = res_q.status;
  assign out_o.bytes_used = res_q.bytes_used;

endmodule

### rtl/hex_varint_decoder_top.sv
// hex varint decoder
// in_i carries one ascii character per transaction, with new_number marking
// the first character of a number and past_end marking a position beyond the
// buffer. pairs of hex digits form bytes whose low 7 bits are shifted into a
// 64-bit value, most significant group first; a byte with bit 7 set ends it.
// out_o carries at most one result per number: the value, a status (ok, bad
// hex pair, too many groups) and the number of byte pairs used.
// throughput: one character per cycle while the output register is free,
// set by the combinational nibble decode and shift-or into the accumulator
// register. the result is registered and valid in the cycle after the
// character that completes it is accepted.
// the result sits in one output register; in_i.ready is high while that
// register is empty or being emptied in the same cycle, so a stalled receiver
// holds off new characters only while a result is waiting.
// reset clears the decoder to idle and empties the output register; characters
// arriving while idle without new_number are dropped.
module hex_varint_decoder_top import hvd_pkg::*; #(
  parameter int unsigned MAX_GROUPS = 10
) (
  input logic clk_i,
  input logic rst_ni,
  hvd_in_if.sink    in_i,
  hvd_out_if.source out_o
);

  localparam logic [CountWidth-1:0] MaxGroups = CountWidth'(MAX_GROUPS);

  logic                   active_q, active_d;
  logic                   second_q, second_d;
  logic [3:0]             high_q, high_d;
  logic                   bad_q, bad_d;
  logic [NumberWidth-1:0] acc_q, acc_d;
  logic [CountWidth-1:0]  count_q, count_d;

  logic    free;
  logic    accept;
  logic    emit;
  result_t res;

  logic                   act;
  logic                   sd;
  logic                   pb;
  logic [3:0]             hn;
  logic [NumberWidth-1:0] acc;
  logic [CountWidth-1:0]  cnt;
  logic [CountWidth-1:0]  cnt_n;
  logic [NumberWidth-1:0] acc_n;
  logic [7:0]             byte_v;
  nibble_t                dec;
  logic                   ok;
  logic [3:0]             nib;

  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  always_comb begin
    act    = active_q || in_i.new_number;
    sd     = in_i.new_number ? 1'b0 : second_q;
    pb     = in_i.new_number ? 1'b0 : bad_q;
    hn     = in_i.new_number ? 4'd0 : high_q;
    acc    = in_i.new_number ? '0 : acc_q;
    cnt    = in_i.new_number ? '0 : count_q;
    dec    = hex_nibble(in_i.ch);
    ok     = dec.ok && !in_i.past_end;
    nib    = ok ? dec.nib : 4'd0;
    cnt_n  = cnt + CountWidth'(1);
    byte_v = {hn, nib};
    acc_n  = {acc[NumberWidth-GroupBits-1:0], byte_v[GroupBits-1:0]};

    active_d = active_q;
    second_d = second_q;
    high_d   = high_q;
    bad_d    = bad_q;
    acc_d    = acc_q;
    count_d  = count_q;
    emit     = 1'b0;
    res.number     = acc;
    res.status     = STATUS_OK;
    res.bytes_used = cnt_n;

    if (accept && act) begin
      active_d = 1'b1;
      bad_d    = pb;
      high_d   = hn;
      acc_d    = acc;
      count_d  = cnt;
      if (!sd) begin
        high_d   = nib;
        bad_d    = !ok;
        second_d = 1'b1;
      end else begin
        second_d = 1'b0;
        count_d  = cnt_n;
        if (pb || !ok) begin
          emit       = 1'b1;
          res.status = STATUS_BAD_PAIR;
        end else begin
          acc_d      = acc_n;
          res.number = acc_n;
          if (byte_v[7]) begin
            emit       = 1'b1;
            res.status = STATUS_OK;
          end else if (cnt_n >= MaxGroups) begin
            emit       = 1'b1;
            res.status = STATUS_TOO_MANY;
          end
        end
        if (emit) begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      second_q <= 1'b0;
      high_q   <= 4'd0;
      bad_q    <= 1'b0;
      acc_q    <= '0;
      count_q  <= '0;
    end else begin
      active_q <= active_d;
      second_q <= second_d;
      high_q   <= high_d;
      bad_q    <= bad_d;
      acc_q    <= acc_d;
      count_q  <= count_d;
    end
  end

  hvd_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (emit),
    .res_i  (res),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

### rtl/hvd_checker.sv
module hvd_checker import hvd_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [NumberWidth-1:0] number_i,
  input logic [CountWidth-1:0]  bytes_used_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(number_i))
    else $error("stalled result changed");

  // a waiting result blocks new characters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input accepted while result stalled");

  // a new result follows an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without input transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (bytes_used_i >= 4'd1) && (bytes_used_i <= 4'd10))
    else $error("bytes_used out of range");

endmodule

bind hex_varint_decoder_top hvd_checker u_hvd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .number_i     (out_o.number),
  .bytes_used_i (out_o.bytes_used)
);

### tb/tb_hex_varint_decoder_top.sv
`timescale 1ns / 100ps

module tb_hex_varint_decoder_top import hvd_pkg::*;;

  localparam int unsigned MaxPairs      = 10;
  localparam int unsigned CharTarget    = 1250;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned SettleCycles  = 10;
  localparam int unsigned ReportLimit   = 10;

  typedef struct {
    logic [CharWidth-1:0] ch;
    bit                   start;
    bit                   past;
    bit                   typed;
    result_t              want;
  } char_row_t;

  logic clk;
  logic rst_n;

  hvd_in_if  in_if ();
  hvd_out_if out_if ();

  hex_varint_decoder_top #(
    .MAX_GROUPS(MaxPairs)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // decoder state as seen by the predictor
  bit                     num_active;
  bit                     num_second;
  logic [3:0]             num_high;
  bit                     num_pair_bad;
  logic [NumberWidth-1:0] num_value;
  logic [CountWidth-1:0]  num_pairs;

  result_t     pending_numbers[$];
  char_row_t   char_script[$];
  int unsigned decoded_chars;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit hex_value(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
      return 1'b1;
    end
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit decode_char(input logic [7:0] c, input bit start, input bit past,
                                     output result_t res, output bit consumed);
    logic [3:0] nib;
    bit         ok;
    logic [7:0] byte_v;
    res      = '0;
    consumed = 1'b0;
    if (start) begin
      num_active   = 1'b1;
      num_second   = 1'b0;
      num_high     = 4'd0;
      num_pair_bad = 1'b0;
      num_value    = '0;
      num_pairs    = '0;
    end
    if (!num_active) return 1'b0;
    consumed = 1'b1;
    ok = hex_value(c, nib) && !past;
    if (!ok) nib = 4'd0;
    if (!num_second) begin
      num_high     = nib;
      num_pair_bad = !ok;
      num_second   = 1'b1;
      return 1'b0;
    end
    num_second     = 1'b0;
    num_pairs      = num_pairs + 1'b1;
    res.bytes_used = num_pairs;
    res.number     = num_value;
    if (num_pair_bad || !ok) begin
      res.status = STATUS_BAD_PAIR;
      num_active = 1'b0;
      return 1'b1;
    end
    byte_v     = {num_high, nib};
    num_value  = {num_value[NumberWidth-GroupBits-1:0], byte_v[6:0]};
    res.number = num_value;
    if (byte_v[7]) begin
      res.status = STATUS_OK;
      num_active = 1'b0;
      return 1'b1;
    end
    if (num_pairs >= MaxPairs) begin
      res.status = STATUS_TOO_MANY;
      num_active = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (($urandom_range(0, 1) != 0) ? 8'h57 : 8'h37) + 8'(v);
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    logic [3:0] v;
    do c = 8'($urandom_range(0, 255)); while (hex_value(c, v));
    return c;
  endfunction

  function automatic void add_row(input logic [7:0] c, input bit start, input bit past);
    char_row_t row;
    row.ch    = c;
    row.start = start;
    row.past  = past;
    row.typed = 1'b0;
    row.want  = '0;
    char_script.push_back(row);
  endfunction

  function automatic void add_checked(input logic [7:0] c, input bit start, input bit past,
                                      input logic [NumberWidth-1:0] number,
                                      input status_e status, input logic [3:0] used);
    char_row_t row;
    row.ch              = c;
    row.start           = start;
    row.past            = past;
    row.typed           = 1'b1;
    row.want.number     = number;
    row.want.status     = status;
    row.want.bytes_used = used;
    char_script.push_back(row);
  endfunction

  task automatic send_char(input logic [7:0] c, input bit start, input bit past,
                           input bit typed = 1'b0, input result_t want = '0);
    int unsigned gap;
    result_t     res;
    bit          got;
    bit          consumed;
    gap = no_gaps ? 0 : gap_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.ch         <= c;
    in_if.new_number <= start;
    in_if.past_end   <= past;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    got = decode_char(c, start, past, res, consumed);
    if (consumed) decoded_chars++;
    if (typed) begin
      pending_numbers.push_back(want);
    end else if (got) begin
      pending_numbers.push_back(res);
    end
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_numbers.size() != 0);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit start);
    send_char(nibble_char(b[7:4]), start, 1'b0);
    send_char(nibble_char(b[3:0]), 1'b0, 1'b0);
  endtask

  task automatic send_bad_digit(input bit start);
    if ($urandom_range(0, 2) == 0) begin
      send_char(8'($urandom_range(0, 255)), start, 1'b1);
    end else begin
      send_char(junk_char(), start, 1'b0);
    end
  endtask

  task automatic send_bad_byte(input bit start);
    if ($urandom_range(0, 1) != 0) begin
      send_bad_digit(start);
      send_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    end else begin
      send_char(nibble_char(4'($urandom_range(0, 15))), start, 1'b0);
      send_bad_digit(1'b0);
    end
  endtask

  task automatic send_number();
    int unsigned kind;
    int unsigned n;
    int unsigned bad_at;
    int unsigned pick;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    // stray characters, ignored while idle
    if (kind >= 94) begin
      repeat ($urandom_range(1, 4)) begin
        send_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
      return;
    end
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, MaxPairs) : $urandom_range(1, 4);
    if (kind >= 70 && kind < 78) n = MaxPairs;
    bad_at = (kind >= 78 && kind < 88) ? $urandom_range(0, n - 1) : n;
    for (int i = 0; i < n; i++) begin
      if (i == bad_at) begin
        send_bad_byte(i == 0);
        return;
      end
      // cut short, the next start flag drops the partial number
      if (kind >= 88 && i == n - 1) begin
        if ($urandom_range(0, 1) != 0) begin
          send_char(nibble_char(4'($urandom_range(0, 15))), i == 0, 1'b0);
        end
        return;
      end
      pick = $urandom_range(0, 9);
      b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'h7f : 8'($urandom_range(0, 127));
      if (kind < 70 && i == n - 1) b[7] = 1'b1;
      send_byte(b, i == 0);
    end
  endtask

  // receiver side
  initial begin
    int unsigned stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 4) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin : check_numbers
    result_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_numbers.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("%0t: unexpected transaction number %h status %0d bytes_used %0d",
                   $realtime, out_if.number, out_if.status, out_if.bytes_used);
        end
      end else begin
        want = pending_numbers.pop_front();
        if (out_if.number !== want.number || out_if.status !== want.status ||
            out_if.bytes_used !== want.bytes_used) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: mismatch number exp %h act %h status exp %0d act %0d",
                     $realtime, want.number, out_if.number, want.status, out_if.status);
            $display("%0t: mismatch bytes_used exp %0d act %0d",
                     $realtime, want.bytes_used, out_if.bytes_used);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    decoded_chars = 0;
    mismatches    = 0;
    idle_cycles   = 0;
    no_gaps       = 1'b0;
    num_active    = 1'b0;
    num_second    = 1'b0;
    num_high      = 4'd0;
    num_pair_bad  = 1'b0;
    num_value     = '0;
    num_pairs     = '0;
    rst_n = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.ch         <= 8'h00;
    in_if.new_number <= 1'b0;
    in_if.past_end   <= 1'b0;

    // idle character, single end byte, bad first digit, past end, restart
    add_row("A", 1'b0, 1'b0);
    add_row("8", 1'b1, 1'b0);
    add_checked("0", 1'b0, 1'b0, '0, STATUS_OK, 4'd1);
    add_row("g", 1'b1, 1'b0);
    add_checked("0", 1'b0, 1'b0, '0, STATUS_BAD_PAIR, 4'd1);
    add_row("1", 1'b1, 1'b0);
    add_checked(8'hff, 1'b0, 1'b1, '0, STATUS_BAD_PAIR, 4'd1);
    add_row("5", 1'b1, 1'b0);
    add_row("F", 1'b1, 1'b0);
    add_checked("f", 1'b0, 1'b0, 64'h7f, STATUS_OK, 4'd1);
    // ten full groups with no end mark
    for (int i = 0; i < MaxPairs; i++) begin
      add_row("7", i == 0, 1'b0);
      if (i < MaxPairs - 1) begin
        add_row((i % 2 == 0) ? "F" : "f", 1'b0, 1'b0);
      end else begin
        add_checked("F", 1'b0, 1'b0, '1, STATUS_TOO_MANY, 4'(MaxPairs));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (char_script[k]) begin
      send_char(char_script[k].ch, char_script[k].start, char_script[k].past,
                char_script[k].typed, char_script[k].want);
    end
    hold_until_drained();

    while (decoded_chars < CharTarget) begin
      if ($urandom_range(0, 39) == 0) no_gaps = ($urandom_range(0, 2) == 0);
      send_number();
      if ($urandom_range(0, 29) == 0) hold_until_drained();
    end

    in_if.valid <= 1'b0;
    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && pending_numbers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/hvd_pkg.sv
rtl/hvd_if.sv
rtl/hvd_out_reg.sv
rtl/hex_varint_decoder_top.sv
rtl/hvd_checker.sv
tb/tb_hex_varint_decoder_top.sv
